// ===== src/irctok_pkg.sv =====
`timescale 1ns / 1ps
// irctok_pkg: types and character constants shared by the irc line tokenizer
// used by irctok_step, irc_line_tokenizer and irctok_checker; depends on nothing

package irctok_pkg;

	// parse phase of the current line
	typedef enum logic [3:0] {
		PH_CMD       = 4'd0,
		PH_NUM       = 4'd1,
		PH_NUM_AFTER = 4'd2,
		PH_STR       = 4'd3,
		PH_PARAMS    = 4'd4,
		PH_MID       = 4'd5,
		PH_TRAIL     = 4'd6,
		PH_CR        = 4'd7,
		PH_LF        = 4'd8,
		PH_DONE      = 4'd9,
		PH_ERR       = 4'd10
	} phase_t;

	// role of one byte
	typedef enum logic [2:0] {
		ROLE_SEP   = 3'd0,
		ROLE_CMD   = 3'd1,
		ROLE_MID   = 3'd2,
		ROLE_TRAIL = 3'd3,
		ROLE_CRLF  = 3'd4,
		ROLE_IGN   = 3'd5
	} role_t;

	// line verdict, also used as the sticky error code
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_BAD_CMD = 2'd2,
		ST_NO_CRLF = 2'd3
	} status_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam logic [9:0] COUNT_MAX = 10'h3ff;

	// per-line parse state
	typedef struct packed {
		phase_t      phase;
		logic [9:0]  byte_count;
		logic [3:0]  params_seen;
		logic [9:0]  token_length;
		logic [1:0]  digit_count;
		logic        fourth_not_space;
		status_t     error_code;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:            PH_CMD,
		byte_count:       10'd0,
		params_seen:      4'd0,
		token_length:     10'd0,
		digit_count:      2'd0,
		fourth_not_space: 1'b0,
		error_code:       ST_OK
	};

	// result of one byte
	typedef struct packed {
		role_t       byte_role;
		logic [3:0]  param_index;
		logic        token_start;
		logic        done_res;
		status_t     status;
		logic [3:0]  param_count;
		logic        numeric_command;
	} result_t;

endpackage

// ===== src/irctok_step.sv =====
`timescale 1ns / 1ps
// irctok_step: combinational classification of one byte and next parse state
// depends on irctok_pkg

module irctok_step #(
	parameter int MAX_PARAMS = 15,
	parameter int MAX_LINE   = 512
) (
	input  irctok_pkg::state_t  cur,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output irctok_pkg::state_t  nxt,
	output irctok_pkg::result_t res
);

	localparam logic [3:0] PARAM_LIM = 4'(MAX_PARAMS);
	localparam logic [9:0] LINE_LIM  = 10'(MAX_LINE);

	function automatic logic is_ws(input logic [7:0] b);
		is_ws = (b == irctok_pkg::CH_SPACE) || (b >= irctok_pkg::CH_TAB && b <= irctok_pkg::CH_CR);
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		is_dig = (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alp(input logic [7:0] b);
		is_alp = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	endfunction

	// byte classification and state update
	always_comb begin
		irctok_pkg::state_t  st;
		irctok_pkg::role_t   role;
		irctok_pkg::status_t verdict;
		logic [3:0]          idx;
		logic                start;
		logic                go_params;
		logic                go_cr;

		st        = cur;
		role      = irctok_pkg::ROLE_SEP;
		idx       = 4'd0;
		start     = 1'b0;
		go_params = 1'b0;
		go_cr     = 1'b0;
		verdict   = irctok_pkg::ST_OK;

		if (cur.byte_count != irctok_pkg::COUNT_MAX) begin
			st.byte_count = cur.byte_count + 10'd1;
		end

		if (cur.byte_count >= LINE_LIM) begin
			role = irctok_pkg::ROLE_IGN;
		end else begin
			case (cur.phase)
				irctok_pkg::PH_CMD: begin
					if (is_dig(data_byte)) begin
						st.digit_count  = 2'd1;
						role            = irctok_pkg::ROLE_CMD;
						start           = 1'b1;
						st.token_length = 10'd1;
						st.phase        = irctok_pkg::PH_NUM;
					end else if (is_alp(data_byte)) begin
						role            = irctok_pkg::ROLE_CMD;
						start           = 1'b1;
						st.token_length = 10'd1;
						st.phase        = irctok_pkg::PH_STR;
					end else begin
						st.error_code = irctok_pkg::ST_BAD_CMD;
						st.phase      = irctok_pkg::PH_ERR;
						role          = irctok_pkg::ROLE_IGN;
					end
				end
				irctok_pkg::PH_NUM: begin
					if (is_dig(data_byte)) begin
						role = irctok_pkg::ROLE_CMD;
						if (cur.token_length != irctok_pkg::COUNT_MAX) begin
							st.token_length = cur.token_length + 10'd1;
						end
						st.digit_count = cur.digit_count + 2'd1;
						if (st.digit_count == 2'd3) begin
							st.phase = irctok_pkg::PH_NUM_AFTER;
						end
					end else begin
						st.error_code = irctok_pkg::ST_BAD_CMD;
						st.phase      = irctok_pkg::PH_ERR;
						role          = irctok_pkg::ROLE_IGN;
					end
				end
				irctok_pkg::PH_NUM_AFTER: begin
					if (data_byte == irctok_pkg::CH_SPACE) begin
						role     = irctok_pkg::ROLE_SEP;
						st.phase = irctok_pkg::PH_PARAMS;
					end else begin
						st.fourth_not_space = 1'b1;
						go_params           = 1'b1;
					end
				end
				irctok_pkg::PH_STR: begin
					if (data_byte == irctok_pkg::CH_SPACE) begin
						role     = irctok_pkg::ROLE_SEP;
						st.phase = irctok_pkg::PH_PARAMS;
					end else if (is_ws(data_byte)) begin
						go_params = 1'b1;
					end else if (is_alp(data_byte)) begin
						role = irctok_pkg::ROLE_CMD;
						if (cur.token_length != irctok_pkg::COUNT_MAX) begin
							st.token_length = cur.token_length + 10'd1;
						end
					end else begin
						st.error_code = irctok_pkg::ST_BAD_CMD;
						st.phase      = irctok_pkg::PH_ERR;
						role          = irctok_pkg::ROLE_IGN;
					end
				end
				irctok_pkg::PH_PARAMS: begin
					go_params = 1'b1;
				end
				irctok_pkg::PH_MID: begin
					if (data_byte == irctok_pkg::CH_SPACE) begin
						role     = irctok_pkg::ROLE_SEP;
						st.phase = irctok_pkg::PH_PARAMS;
					end else if (is_ws(data_byte)) begin
						go_cr = 1'b1;
					end else begin
						role = irctok_pkg::ROLE_MID;
						idx  = cur.params_seen - 4'd1;
						if (cur.token_length != irctok_pkg::COUNT_MAX) begin
							st.token_length = cur.token_length + 10'd1;
						end
					end
				end
				irctok_pkg::PH_TRAIL: begin
					if (data_byte == irctok_pkg::CH_NUL || data_byte == irctok_pkg::CH_CR ||
						data_byte == irctok_pkg::CH_LF) begin
						if (cur.token_length == 10'd0) begin
							st.error_code = irctok_pkg::ST_NO_CRLF;
							st.phase      = irctok_pkg::PH_ERR;
							role          = irctok_pkg::ROLE_IGN;
						end else begin
							go_cr = 1'b1;
						end
					end else begin
						// first body byte makes the trailing parameter count
						if (cur.token_length == 10'd0) begin
							st.params_seen = cur.params_seen + 4'd1;
						end
						role = irctok_pkg::ROLE_TRAIL;
						idx  = st.params_seen - 4'd1;
						if (cur.token_length != irctok_pkg::COUNT_MAX) begin
							st.token_length = cur.token_length + 10'd1;
						end
					end
				end
				irctok_pkg::PH_CR: begin
					go_cr = 1'b1;
				end
				irctok_pkg::PH_LF: begin
					if (data_byte == irctok_pkg::CH_LF) begin
						role     = irctok_pkg::ROLE_CRLF;
						st.phase = irctok_pkg::PH_DONE;
					end else begin
						st.error_code = irctok_pkg::ST_NO_CRLF;
						st.phase      = irctok_pkg::PH_ERR;
						role          = irctok_pkg::ROLE_IGN;
					end
				end
				default: begin
					role = irctok_pkg::ROLE_IGN;
				end
			endcase
		end

		// start of a parameter, or end of the parameter table
		if (go_params) begin
			if (cur.params_seen >= PARAM_LIM || is_ws(data_byte)) begin
				go_cr = 1'b1;
			end else if (data_byte == irctok_pkg::CH_COLON) begin
				role            = irctok_pkg::ROLE_TRAIL;
				start           = 1'b1;
				idx             = cur.params_seen;
				st.token_length = 10'd0;
				st.phase        = irctok_pkg::PH_TRAIL;
			end else begin
				role            = irctok_pkg::ROLE_MID;
				start           = 1'b1;
				idx             = cur.params_seen;
				st.params_seen  = cur.params_seen + 4'd1;
				st.token_length = 10'd1;
				st.phase        = irctok_pkg::PH_MID;
			end
		end

		// carriage return expected
		if (go_cr) begin
			if (data_byte == irctok_pkg::CH_CR) begin
				role     = irctok_pkg::ROLE_CRLF;
				st.phase = irctok_pkg::PH_LF;
			end else begin
				st.error_code = irctok_pkg::ST_NO_CRLF;
				st.phase      = irctok_pkg::PH_ERR;
				role          = irctok_pkg::ROLE_IGN;
			end
		end

		if (role != irctok_pkg::ROLE_MID && role != irctok_pkg::ROLE_TRAIL) begin
			idx = 4'd0;
		end

		// verdict on the last byte
		if (st.byte_count < 10'd2) begin
			verdict = irctok_pkg::ST_SHORT;
		end else if (st.error_code == irctok_pkg::ST_BAD_CMD ||
			(st.fourth_not_space && st.byte_count > 10'd5)) begin
			verdict = irctok_pkg::ST_BAD_CMD;
		end else if (st.phase != irctok_pkg::PH_DONE) begin
			verdict = irctok_pkg::ST_NO_CRLF;
		end else begin
			verdict = irctok_pkg::ST_OK;
		end

		res.byte_role       = role;
		res.param_index     = idx;
		res.token_start     = start;
		res.done_res        = last_byte;
		res.status          = irctok_pkg::ST_OK;
		res.param_count     = 4'd0;
		res.numeric_command = 1'b0;
		if (last_byte) begin
			res.status = verdict;
			if (verdict == irctok_pkg::ST_OK || verdict == irctok_pkg::ST_NO_CRLF) begin
				res.param_count     = st.params_seen;
				res.numeric_command = (st.digit_count == 2'd3);
			end
		end

		nxt = last_byte ? irctok_pkg::STATE_RESET : st;
	end

endmodule

// ===== src/irc_line_tokenizer.sv =====
`timescale 1ns / 1ps
// irc_line_tokenizer: top level, input register, parse state and result register
// depends on irctok_pkg and irctok_step
//
// Usage:
//   Bytes of one IRC line enter on the byte channel (byte_valid, byte_stall,
//   data_byte, last_byte), last_byte set on the final byte of the line.
//   One result per byte leaves on the result channel (res_valid, res_stall):
//   byte_role, param_index, token_start, and on the last byte done_res with
//   status, param_count and numeric_command.
//   A transaction takes place at a rising edge with valid high and stall low.
//   A byte taken goes into the input register; its result then goes into the result register.
//   Throughput: one byte per cycle while the receiver does not stall; the parse state
//   updates in a single pass of short logic between the input and result registers.
//   After the last byte of a line the parse state is back at its reset value.
//   When the receiver stalls, the result register holds and one more byte
//   waits in the input register; then byte_stall rises.
//   Reset (arst_n low) empties both registers and returns the parse state to
//   the start of a command.

module irc_line_tokenizer #(
	parameter int MAX_PARAMS = 15,
	parameter int MAX_LINE   = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] byte_role,
	output logic [3:0] param_index,
	output logic       token_start,
	output logic       done_res,
	output logic [1:0] status,
	output logic [3:0] param_count,
	output logic       numeric_command
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                valid_s2;
	irctok_pkg::result_t res_s2;
	irctok_pkg::state_t  state_q;
	irctok_pkg::state_t  state_d;
	irctok_pkg::result_t res_d;
	logic                take_s2;
	logic                accept;

	// flow control
	assign take_s2    = valid_s1 && (!valid_s2 || !res_stall);
	assign byte_stall = valid_s1 && !take_s2;
	assign accept     = byte_valid && !byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// byte classification
	irctok_step #(
		.MAX_PARAMS(MAX_PARAMS),
		.MAX_LINE  (MAX_LINE)
	) u_step (
		.cur      (state_q),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.nxt      (state_d),
		.res      (res_d)
	);

	// parse state, advances once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irctok_pkg::STATE_RESET;
		end else if (take_s2) begin
			state_q <= state_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid       = valid_s2;
	assign byte_role       = res_s2.byte_role;
	assign param_index     = res_s2.param_index;
	assign token_start     = res_s2.token_start;
	assign done_res        = res_s2.done_res;
	assign status          = res_s2.status;
	assign param_count     = res_s2.param_count;
	assign numeric_command = res_s2.numeric_command;

endmodule

// ===== src/irctok_checker.sv =====
`timescale 1ns / 1ps
// irctok_checker: port-level checks for irc_line_tokenizer, bound to the top level
// depends on irctok_pkg and irc_line_tokenizer

module irctok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic [2:0] byte_role,
	input logic [3:0] param_index,
	input logic       done_res,
	input logic [1:0] status,
	input logic [3:0] param_count,
	input logic       numeric_command
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// verdict fields are quiet away from the last byte
	a_quiet_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> status == irctok_pkg::ST_OK && param_count == 4'd0 &&
			!numeric_command)
		else $error("verdict fields set on a byte that is not the last");

	// a parameter index only on parameter bytes
	a_index_role: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_role != irctok_pkg::ROLE_MID &&
			byte_role != irctok_pkg::ROLE_TRAIL |-> param_index == 4'd0)
		else $error("parameter index on a byte that is not a parameter");

	// short lines and bad commands report no parameters
	a_count_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == irctok_pkg::ST_SHORT || status == irctok_pkg::ST_BAD_CMD)
			|-> param_count == 4'd0 && !numeric_command)
		else $error("parameter count reported with a failed command");

	// the input side stalls only while results are held back
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid && res_stall)
		else $error("input stalled with the result side free");

endmodule

bind irc_line_tokenizer irctok_checker u_irctok_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.byte_stall     (byte_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.byte_role      (byte_role),
	.param_index    (param_index),
	.done_res       (done_res),
	.status         (status),
	.param_count    (param_count),
	.numeric_command(numeric_command)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for irc_line_tokenizer, byte in and labeled byte out
// checks each result against a line parser kept in the bench or a typed-in result; depends on irctok_pkg

module tb_top;

	localparam int MAX_PARAMS = 15;
	localparam int MAX_LINE   = 512;
	localparam int RAND_BYTES = 1600;
	localparam int WATCHDOG   = 2000;
	localparam int DRAIN      = 10;

	// one byte to send, with the result typed in where it is obvious
	typedef struct packed {
		logic [7:0]          data;
		logic                last;
		logic                typed;
		irctok_pkg::result_t want;
	} byte_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] byte_role;
	logic [3:0] param_index;
	logic       token_start;
	logic       done_res;
	logic [1:0] status;
	logic [3:0] param_count;
	logic       numeric_command;

	byte_item_t          byte_fifo [$];
	irctok_pkg::result_t result_fifo [$];
	logic [7:0]          line_buf [$];
	byte_item_t          cur_item;

	int  err_count = 0;
	int  res_num = 0;
	int  idle_cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  feed_calm = 1'b0;
	bit  sink_calm = 1'b0;
	bit  feed_done = 1'b0;

	// bench copy of the line parse state
	irctok_pkg::phase_t  ps_phase;
	logic [9:0]          ps_bytes;
	logic [3:0]          ps_params;
	logic [9:0]          ps_tlen;
	logic [1:0]          ps_digits;
	logic                ps_fourth;
	irctok_pkg::status_t ps_err;
	irctok_pkg::role_t   cur_role;
	logic [3:0]          cur_idx;
	logic                cur_start;

	// directed lines: short line, bad first byte, full numeric line,
	// numeric command glued to a parameter, tab after command, empty trailing
	byte_item_t dir_tab [26] = '{
		{"A", 1'b1, 1'b1, irctok_pkg::ROLE_CMD, 4'd0, 1'b1, 1'b1,
			irctok_pkg::ST_SHORT, 4'd0, 1'b0},
		{8'h00, 1'b0, 1'b1, irctok_pkg::ROLE_IGN, 4'd0, 1'b0, 1'b0,
			irctok_pkg::ST_OK, 4'd0, 1'b0},
		{8'hff, 1'b1, 1'b1, irctok_pkg::ROLE_IGN, 4'd0, 1'b0, 1'b1,
			irctok_pkg::ST_BAD_CMD, 4'd0, 1'b0},
		{"0",                  1'b0, 1'b0, 16'h0},
		{"0",                  1'b0, 1'b0, 16'h0},
		{"1",                  1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_SPACE, 1'b0, 1'b0, 16'h0},
		{"a",                  1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_SPACE, 1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_COLON, 1'b0, 1'b0, 16'h0},
		{"b",                  1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_CR,    1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_LF, 1'b1, 1'b1, irctok_pkg::ROLE_CRLF, 4'd0, 1'b0, 1'b1,
			irctok_pkg::ST_OK, 4'd2, 1'b1},
		{"1",                  1'b0, 1'b0, 16'h0},
		{"2",                  1'b0, 1'b0, 16'h0},
		{"3",                  1'b0, 1'b0, 16'h0},
		{"x",                  1'b0, 1'b0, 16'h0},
		{"y",                  1'b0, 1'b0, 16'h0},
		{"z", 1'b1, 1'b1, irctok_pkg::ROLE_MID, 4'd0, 1'b0, 1'b1,
			irctok_pkg::ST_BAD_CMD, 4'd0, 1'b0},
		{"A",                  1'b0, 1'b0, 16'h0},
		{"b",                  1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_TAB, 1'b1, 1'b1, irctok_pkg::ROLE_IGN, 4'd0, 1'b0, 1'b1,
			irctok_pkg::ST_NO_CRLF, 4'd0, 1'b0},
		{"x",                  1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_SPACE, 1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_COLON, 1'b0, 1'b0, 16'h0},
		{irctok_pkg::CH_CR, 1'b1, 1'b1, irctok_pkg::ROLE_IGN, 4'd0, 1'b0, 1'b1,
			irctok_pkg::ST_NO_CRLF, 4'd0, 1'b0}
	};

	irc_line_tokenizer #(
		.MAX_PARAMS(MAX_PARAMS),
		.MAX_LINE(MAX_LINE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.byte_role(byte_role),
		.param_index(param_index),
		.token_start(token_start),
		.done_res(done_res),
		.status(status),
		.param_count(param_count),
		.numeric_command(numeric_command)
	);

	always #4 clk = ~clk;

	// character classes
	function automatic bit is_ws(input logic [7:0] b);
		return b == irctok_pkg::CH_SPACE || (b >= irctok_pkg::CH_TAB && b <= irctok_pkg::CH_CR);
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic void line_reset();
		ps_phase  = irctok_pkg::PH_CMD;
		ps_bytes  = 10'd0;
		ps_params = 4'd0;
		ps_tlen   = 10'd0;
		ps_digits = 2'd0;
		ps_fourth = 1'b0;
		ps_err    = irctok_pkg::ST_OK;
	endfunction

	function automatic void line_fail(input irctok_pkg::status_t code);
		ps_err   = code;
		ps_phase = irctok_pkg::PH_ERR;
		cur_role = irctok_pkg::ROLE_IGN;
	endfunction

	function automatic void bump_tlen();
		if (ps_tlen < irctok_pkg::COUNT_MAX)
			ps_tlen = ps_tlen + 10'd1;
	endfunction

	// only a carriage return may come here
	function automatic void expect_cr(input logic [7:0] b);
		if (b == irctok_pkg::CH_CR) begin
			cur_role = irctok_pkg::ROLE_CRLF;
			ps_phase = irctok_pkg::PH_LF;
		end else begin
			line_fail(irctok_pkg::ST_NO_CRLF);
		end
	endfunction

	// first byte of a parameter, a trailing ':' or the line end
	function automatic void param_begin(input logic [7:0] b);
		if (ps_params >= MAX_PARAMS || is_ws(b)) begin
			ps_phase = irctok_pkg::PH_CR;
			expect_cr(b);
		end else if (b == irctok_pkg::CH_COLON) begin
			cur_role  = irctok_pkg::ROLE_TRAIL;
			cur_start = 1'b1;
			cur_idx   = ps_params;
			ps_tlen   = 10'd0;
			ps_phase  = irctok_pkg::PH_TRAIL;
		end else begin
			cur_role  = irctok_pkg::ROLE_MID;
			cur_start = 1'b1;
			cur_idx   = ps_params;
			ps_params = ps_params + 4'd1;
			ps_tlen   = 10'd1;
			ps_phase  = irctok_pkg::PH_MID;
		end
	endfunction

	// label one byte, advance the parse state, give the verdict on the last byte
	function automatic irctok_pkg::result_t classify_byte(input logic [7:0] b, input logic last);
		irctok_pkg::result_t r;
		logic [9:0]          pos;
		pos       = ps_bytes;
		cur_role  = irctok_pkg::ROLE_SEP;
		cur_idx   = 4'd0;
		cur_start = 1'b0;
		if (ps_bytes < irctok_pkg::COUNT_MAX)
			ps_bytes = ps_bytes + 10'd1;
		if (pos >= MAX_LINE) begin
			cur_role = irctok_pkg::ROLE_IGN;
		end else begin
			case (ps_phase)
				irctok_pkg::PH_CMD: begin
					if (is_digit(b)) begin
						ps_digits = 2'd1;
						cur_role  = irctok_pkg::ROLE_CMD;
						cur_start = 1'b1;
						ps_tlen   = 10'd1;
						ps_phase  = irctok_pkg::PH_NUM;
					end else if (is_letter(b)) begin
						cur_role  = irctok_pkg::ROLE_CMD;
						cur_start = 1'b1;
						ps_tlen   = 10'd1;
						ps_phase  = irctok_pkg::PH_STR;
					end else begin
						line_fail(irctok_pkg::ST_BAD_CMD);
					end
				end
				irctok_pkg::PH_NUM: begin
					if (is_digit(b)) begin
						cur_role = irctok_pkg::ROLE_CMD;
						bump_tlen();
						ps_digits = ps_digits + 2'd1;
						if (ps_digits == 2'd3)
							ps_phase = irctok_pkg::PH_NUM_AFTER;
					end else begin
						line_fail(irctok_pkg::ST_BAD_CMD);
					end
				end
				irctok_pkg::PH_NUM_AFTER: begin
					if (b == irctok_pkg::CH_SPACE) begin
						cur_role = irctok_pkg::ROLE_SEP;
						ps_phase = irctok_pkg::PH_PARAMS;
					end else begin
						ps_fourth = 1'b1;
						param_begin(b);
					end
				end
				irctok_pkg::PH_STR: begin
					if (b == irctok_pkg::CH_SPACE) begin
						cur_role = irctok_pkg::ROLE_SEP;
						ps_phase = irctok_pkg::PH_PARAMS;
					end else if (is_ws(b)) begin
						param_begin(b);
					end else if (is_letter(b)) begin
						cur_role = irctok_pkg::ROLE_CMD;
						bump_tlen();
					end else begin
						line_fail(irctok_pkg::ST_BAD_CMD);
					end
				end
				irctok_pkg::PH_PARAMS: begin
					param_begin(b);
				end
				irctok_pkg::PH_MID: begin
					if (b == irctok_pkg::CH_SPACE) begin
						cur_role = irctok_pkg::ROLE_SEP;
						ps_phase = irctok_pkg::PH_PARAMS;
					end else if (is_ws(b)) begin
						ps_phase = irctok_pkg::PH_CR;
						expect_cr(b);
					end else begin
						cur_role = irctok_pkg::ROLE_MID;
						cur_idx  = ps_params - 4'd1;
						bump_tlen();
					end
				end
				irctok_pkg::PH_TRAIL: begin
					if (b == irctok_pkg::CH_NUL || b == irctok_pkg::CH_CR ||
							b == irctok_pkg::CH_LF) begin
						if (ps_tlen == 10'd0) begin
							line_fail(irctok_pkg::ST_NO_CRLF);
						end else begin
							ps_phase = irctok_pkg::PH_CR;
							expect_cr(b);
						end
					end else begin
						if (ps_tlen == 10'd0)
							ps_params = ps_params + 4'd1;
						cur_role = irctok_pkg::ROLE_TRAIL;
						cur_idx  = ps_params - 4'd1;
						bump_tlen();
					end
				end
				irctok_pkg::PH_CR: begin
					expect_cr(b);
				end
				irctok_pkg::PH_LF: begin
					if (b == irctok_pkg::CH_LF) begin
						cur_role = irctok_pkg::ROLE_CRLF;
						ps_phase = irctok_pkg::PH_DONE;
					end else begin
						line_fail(irctok_pkg::ST_NO_CRLF);
					end
				end
				default: begin
					cur_role = irctok_pkg::ROLE_IGN;
				end
			endcase
		end
		if (cur_role != irctok_pkg::ROLE_MID && cur_role != irctok_pkg::ROLE_TRAIL)
			cur_idx = 4'd0;

		r             = '0;
		r.byte_role   = cur_role;
		r.param_index = cur_idx;
		r.token_start = cur_start;
		if (last) begin
			r.done_res = 1'b1;
			if (ps_bytes < 2)
				r.status = irctok_pkg::ST_SHORT;
			else if (ps_err == irctok_pkg::ST_BAD_CMD || (ps_fourth && ps_bytes > 5))
				r.status = irctok_pkg::ST_BAD_CMD;
			else if (ps_phase != irctok_pkg::PH_DONE)
				r.status = irctok_pkg::ST_NO_CRLF;
			else
				r.status = irctok_pkg::ST_OK;
			if (r.status == irctok_pkg::ST_OK || r.status == irctok_pkg::ST_NO_CRLF) begin
				r.param_count     = ps_params;
				r.numeric_command = (ps_digits == 2'd3);
			end
			line_reset();
		end
		return r;
	endfunction

	// random line content
	function automatic logic [7:0] rand_letter();
		int k;
		k = $urandom_range(0, 51);
		return (k < 26) ? 8'("a" + k) : 8'("A" + k - 26);
	endfunction

	function automatic logic [7:0] rand_mid_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (is_ws(b));
		return b;
	endfunction

	function automatic logic [7:0] rand_trail_byte();
		logic [7:0] b;
		do b = 8'($urandom);
		while (b == irctok_pkg::CH_NUL || b == irctok_pkg::CH_CR || b == irctok_pkg::CH_LF);
		return b;
	endfunction

	// move the assembled line into the send queue, marking its final byte
	task automatic queue_line();
		byte_item_t row;
		for (int i = 0; i < line_buf.size(); i++) begin
			row       = '0;
			row.data  = line_buf[i];
			row.last  = (i == line_buf.size() - 1);
			byte_fifo.push_back(row);
		end
		line_buf.delete();
	endtask

	// a line that crosses or nearly reaches the line length limit
	task automatic add_long_line(input int len);
		repeat (4) line_buf.push_back(rand_letter());
		line_buf.push_back(irctok_pkg::CH_SPACE);
		line_buf.push_back(irctok_pkg::CH_COLON);
		while (line_buf.size() < len - 2)
			line_buf.push_back(rand_trail_byte());
		line_buf.push_back(irctok_pkg::CH_CR);
		line_buf.push_back(irctok_pkg::CH_LF);
		queue_line();
	endtask

	// mostly well-formed lines with random content, some noise and broken lines
	task automatic add_random_line();
		int         kind;
		int         np;
		int         n;
		int         k;
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 8);
			repeat (n) line_buf.push_back(8'($urandom));
		end else begin
			if ($urandom_range(0, 1) == 0) begin
				repeat (3) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) line_buf.push_back(rand_letter());
			end
			k = $urandom_range(0, 9);
			np = (k < 7) ? $urandom_range(0, 4) : (k < 9) ? $urandom_range(5, 14) : MAX_PARAMS;
			repeat (np) begin
				line_buf.push_back(irctok_pkg::CH_SPACE);
				do b = rand_mid_byte(); while (b == irctok_pkg::CH_COLON);
				line_buf.push_back(b);
				n = $urandom_range(0, 3);
				repeat (n) line_buf.push_back(rand_mid_byte());
			end
			// optional trailing, sometimes empty
			if ($urandom_range(0, 9) < 6) begin
				line_buf.push_back(irctok_pkg::CH_SPACE);
				line_buf.push_back(irctok_pkg::CH_COLON);
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				repeat (n) line_buf.push_back(rand_trail_byte());
			end
			line_buf.push_back(irctok_pkg::CH_CR);
			line_buf.push_back(irctok_pkg::CH_LF);
			// bytes after the line end
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) line_buf.push_back(8'($urandom));
			end
			// break the line at one spot
			if ($urandom_range(0, 4) == 0) begin
				k = $urandom_range(0, line_buf.size() - 1);
				case ($urandom_range(0, 3))
					0: line_buf[k] = 8'($urandom);
					1: begin
						case ($urandom_range(0, 4))
							0: line_buf[k] = irctok_pkg::CH_SPACE;
							1: line_buf[k] = irctok_pkg::CH_TAB;
							2: line_buf[k] = irctok_pkg::CH_COLON;
							3: line_buf[k] = irctok_pkg::CH_CR;
							default: line_buf[k] = irctok_pkg::CH_NUL;
						endcase
					end
					2: line_buf.insert(k, irctok_pkg::CH_SPACE);
					default: begin
						while (line_buf.size() > k + 1)
							void'(line_buf.pop_back());
					end
				endcase
			end
		end
		queue_line();
	endtask

	// idle length: mostly none, some short, a few long
	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// byte sender: predict on each transaction, then present the next byte
	always @(posedge clk) begin : feed
		irctok_pkg::result_t pred;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				pred = classify_byte(cur_item.data, cur_item.last);
				result_fifo.push_back(cur_item.typed ? cur_item.want : pred);
				if (byte_fifo.size() == 0)
					feed_done = 1'b1;
			end
			if (!byte_valid || !byte_stall) begin
				if (gap_left > 0 || byte_fifo.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					byte_valid <= 1'b0;
				end else begin
					cur_item = byte_fifo.pop_front();
					byte_valid <= 1'b1;
					data_byte  <= cur_item.data;
					last_byte  <= cur_item.last;
					gap_left = idle_len(feed_calm);
					if ($urandom_range(0, 63) == 0)
						feed_calm = !feed_calm;
				end
			end
		end
	end

	// result receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				stall_left = idle_len(sink_calm);
				if ($urandom_range(0, 63) == 0)
					sink_calm = !sink_calm;
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : sink
		irctok_pkg::result_t got;
		irctok_pkg::result_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = {byte_role, param_index, token_start, done_res, status, param_count,
				numeric_command};
			if (result_fifo.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("result %0d arrived with none expected: role %0d idx %0d",
						res_num, got.byte_role, got.param_index);
			end else begin
				want = result_fifo.pop_front();
				if (got.byte_role !== want.byte_role || got.param_index !== want.param_index ||
						got.token_start !== want.token_start || got.done_res !== want.done_res ||
						got.status !== want.status || got.param_count !== want.param_count ||
						got.numeric_command !== want.numeric_command) begin
					err_count++;
					if (err_count <= 10)
						$display("result %0d mismatch: expected %0d/%0d/%b/%b/%0d/%0d/%b got %0d/%0d/%b/%b/%0d/%0d/%b",
							res_num, want.byte_role, want.param_index, want.token_start,
							want.done_res, want.status, want.param_count, want.numeric_command,
							got.byte_role, got.param_index, got.token_start, got.done_res,
							got.status, got.param_count, got.numeric_command);
				end
			end
			res_num++;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("irc_line_tokenizer test failed");
				$finish;
			end
		end
	end

	// stimulus build, reset, and end of run
	initial begin
		int n_lines;
		line_reset();
		foreach (dir_tab[i])
			byte_fifo.push_back(dir_tab[i]);
		n_lines = 0;
		while (byte_fifo.size() < RAND_BYTES + $size(dir_tab)) begin
			add_random_line();
			n_lines++;
			if (n_lines == 30)
				add_long_line($urandom_range(500, MAX_LINE));
			if (n_lines == 70)
				add_long_line($urandom_range(MAX_LINE + 1, MAX_LINE + 28));
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!feed_done)
			@(posedge clk);
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (err_count == 0 && result_fifo.size() == 0)
			$display("irc_line_tokenizer test passed");
		else
			$display("irc_line_tokenizer test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/irctok_pkg.sv
src/irctok_step.sv
src/irc_line_tokenizer.sv
src/irctok_checker.sv
bench/tb_top.sv
